FILE: sv/ffd_pkg.sv
// Shared constants, control-word types and the microprogram of the
// filtered feedback delay core. No dependencies.
package ffd_pkg;

    // Store and sample formats
    localparam int DEPTH       = 131072;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 8;
    localparam int STATE_BITS  = SAMPLE_BITS + FRAC_BITS;

    // Q1.15 gains
    localparam int GAIN_BITS    = 16;
    localparam int FB_BITS      = 15;
    localparam int COEFF_SHIFT  = 15;
    localparam int UNITY        = 32768;
    localparam int FEEDBACK_MAX = 32440;

    // Configuration port
    localparam int CFG_DATA_BITS = 18;
    localparam int CFG_IDX_BITS  = 3;
    localparam int DELAY_BITS    = 18;

    // Register reset values
    localparam int RST_DELAY = 22050;
    localparam int RST_FB    = 9830;
    localparam int RST_MIX   = 16384;
    localparam int RST_LP    = 24350;
    localparam int RST_HP    = 32676;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DELAY = 3'd0,
        CFG_FB    = 3'd1,
        CFG_MIX   = 3'd2,
        CFG_LP    = 3'd3,
        CFG_HP    = 3'd4
    } t_cfg_idx;

    // Sequencer
    localparam int STEP_BITS = 3;

    localparam logic [STEP_BITS-1:0] STEP_LOAD    = 3'd0;
    localparam logic [STEP_BITS-1:0] STEP_LP_MUL  = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_LP_ACC  = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_HP_MUL  = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_HP_SAT  = 3'd4;
    localparam logic [STEP_BITS-1:0] STEP_MIX_MUL = 3'd5;
    localparam logic [STEP_BITS-1:0] STEP_FB_MUL  = 3'd6;
    localparam logic [STEP_BITS-1:0] STEP_STORE   = 3'd7;

    typedef enum logic [1:0] {
        A_LP_DIFF,  // echo*256 - low-pass level
        A_HP_SUM,   // hp_prev + lp - lp_prev
        A_HP        // high-pass output
    } t_mul_a;

    typedef enum logic [1:0] {
        B_LP,
        B_HP,
        B_MIX,
        B_FB
    } t_mul_b;

    typedef enum logic [1:0] {
        J_NONE,
        J_NO_INPUT,
        J_OUT_BUSY
    } t_jump;

    typedef struct packed {
        t_jump                jump;
        logic [STEP_BITS-1:0] target;
        logic                 mul_en;
        t_mul_a               mul_a;
        t_mul_b               mul_b;
        logic                 load;    // take input word, read store
        logic                 lp_upd;  // low-pass accumulate
        logic                 hp_upd;  // high-pass saturate, commit lp
        logic                 y_upd;   // form output sample
        logic                 store;   // write back, present output
    } t_ctrl;

    // Microprogram ROM: one control word per step
    function automatic t_ctrl microcode(input logic [STEP_BITS-1:0] step);
        t_ctrl c;
        c        = '0;
        c.jump   = J_NONE;
        c.mul_a  = A_LP_DIFF;
        c.mul_b  = B_LP;
        c.target = STEP_LOAD;
        unique case (step)
            STEP_LOAD: begin
                c.jump   = J_NO_INPUT;
                c.target = STEP_LOAD;
                c.load   = 1'b1;
            end
            STEP_LP_MUL: begin
                c.mul_en = 1'b1;
                c.mul_a  = A_LP_DIFF;
                c.mul_b  = B_LP;
            end
            STEP_LP_ACC: begin
                c.lp_upd = 1'b1;
            end
            STEP_HP_MUL: begin
                c.mul_en = 1'b1;
                c.mul_a  = A_HP_SUM;
                c.mul_b  = B_HP;
            end
            STEP_HP_SAT: begin
                c.hp_upd = 1'b1;
            end
            STEP_MIX_MUL: begin
                c.mul_en = 1'b1;
                c.mul_a  = A_HP;
                c.mul_b  = B_MIX;
            end
            STEP_FB_MUL: begin
                c.y_upd  = 1'b1;
                c.mul_en = 1'b1;
                c.mul_a  = A_HP;
                c.mul_b  = B_FB;
            end
            STEP_STORE: begin
                c.jump   = J_OUT_BUSY;
                c.target = STEP_STORE;
                c.store  = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: sv/filtered_feedback_delay_core.sv
// Filtered feedback delay core: microcoded sequencer around one shared
// multiplier and a single-port echo store. Depends on ffd_pkg.
//
// Usage
//   Input channel: i_valid / o_stall carry one signed sample word in
//   i_sample_in. Output channel: o_valid / i_stall carry one word in
//   o_sample_out. A word moves at a rising edge with valid high and stall low.
//   Configuration: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle.
//   Index 0 delay, 1 feedback gain, 2 mix gain, 3 low-pass and 4 high-pass
//   coefficient. Other indexes are ignored.
// Timing
//   Input words are taken only in the load step, one per pass of the
//   eight-step microprogram that shares one 34x17 multiplier over the
//   low-pass, high-pass, mix and feedback products. The result is
//   registered in the last step, store; the next input is taken while it waits.
//   On a receiver stall it holds in that step until the output register frees.
// Reset
//   Synchronous, active low. Registers return to their defaults and the
//   filter state to zero. The store is not swept: a fill count marks the
//   entries written since reset and unwritten entries read as zero, so the
//   block takes input straight out of reset.
module filtered_feedback_delay_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [ffd_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [ffd_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  logic                                   i_cfg_we,
    input  logic [ffd_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [ffd_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int SB     = ffd_pkg::SAMPLE_BITS;
    localparam int ST     = ffd_pkg::STATE_BITS;
    localparam int AB     = ffd_pkg::ADDR_BITS;
    localparam int GB     = ffd_pkg::GAIN_BITS;
    localparam int A_W    = ST + 2;
    localparam int B_W    = GB + 1;
    localparam int PROD_W = A_W + B_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SH_OUT = ffd_pkg::COEFF_SHIFT + ffd_pkg::FRAC_BITS;

    localparam logic signed [SUM_W-1:0] HALF_COEF =
        SUM_W'(1) <<< (ffd_pkg::COEFF_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] HALF_OUT = SUM_W'(1) <<< (SH_OUT - 1);

    // Saturate to the filter-state range
    function automatic logic [ST-1:0] sat_state(input logic [SUM_W-1:0] v);
        logic [SUM_W-ST:0] top;
        top = v[SUM_W-1:ST-1];
        if (top == '0 || top == '1) begin
            return v[ST-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(ST-1){1'b0}}} : {1'b0, {(ST-1){1'b1}}};
    endfunction

    // Saturate to the sample range
    function automatic logic [SB-1:0] sat_sample(input logic [SUM_W-1:0] v);
        logic [SUM_W-SB:0] top;
        top = v[SUM_W-1:SB-1];
        if (top == '0 || top == '1) begin
            return v[SB-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    endfunction

    // Configuration registers, stored already capped
    logic [AB-1:0] r_delay;
    logic [GB-1:0] r_g_fb;
    logic [GB-1:0] r_g_mix;
    logic [GB-1:0] r_a_lp;
    logic [GB-1:0] r_a_hp;

    // Sequencer and datapath registers
    logic [ffd_pkg::STEP_BITS-1:0] r_step;
    logic [AB-1:0]                 r_wp;
    logic [AB:0]                   r_fill;
    logic signed [SB-1:0]          r_x;
    logic [SB-1:0]                 r_rdata;
    logic                          r_rd_ok;
    logic signed [ST-1:0]          r_lp;
    logic signed [ST-1:0]          r_lp_new;
    logic signed [ST-1:0]          r_hp;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [SB-1:0]          r_y;
    logic                          r_out_valid;
    logic signed [SB-1:0]          r_out;

    logic [SB-1:0] r_mem [ffd_pkg::DEPTH];

    ffd_pkg::t_ctrl w_ctrl;
    logic           w_jump;
    logic           w_adv;
    logic [AB-1:0]  w_rd;

    logic signed [SB-1:0]    w_echo;
    logic signed [A_W-1:0]   w_mul_a;
    logic [GB-1:0]           w_gain;
    logic signed [B_W-1:0]   w_mul_b;
    logic signed [SUM_W-1:0] w_prod_x;
    logic signed [SUM_W-1:0] w_t_coef;
    logic signed [SUM_W-1:0] w_rnd_coef;
    logic signed [SUM_W-1:0] w_t_out;
    logic signed [SUM_W-1:0] w_rnd_out;
    logic signed [SUM_W-1:0] w_lp_x;
    logic signed [SUM_W-1:0] w_x_x;
    logic signed [SB-1:0]    w_sat_out;

    // Control word and jump decision
    always_comb begin
        w_ctrl = ffd_pkg::microcode(r_step);
        unique case (w_ctrl.jump)
            ffd_pkg::J_NO_INPUT: w_jump = !i_valid;
            ffd_pkg::J_OUT_BUSY: w_jump = r_out_valid && i_stall;
            default:             w_jump = 1'b0;
        endcase
        w_adv = !w_jump;
    end

    assign o_stall      = (r_step != ffd_pkg::STEP_LOAD);
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

    // Read address: zero delay means full depth, i.e. the write position
    assign w_rd = r_wp - r_delay;

    // Multiplier operand selection
    assign w_echo = r_rd_ok ? $signed(r_rdata) : '0;

    always_comb begin
        unique case (w_ctrl.mul_a)
            ffd_pkg::A_LP_DIFF:
                w_mul_a = A_W'($signed({w_echo, {ffd_pkg::FRAC_BITS{1'b0}}}))
                          - A_W'(r_lp);
            ffd_pkg::A_HP_SUM:
                w_mul_a = A_W'(r_hp) + A_W'(r_lp_new) - A_W'(r_lp);
            default:
                w_mul_a = A_W'(r_hp);
        endcase
        unique case (w_ctrl.mul_b)
            ffd_pkg::B_LP:  w_gain = r_a_lp;
            ffd_pkg::B_HP:  w_gain = r_a_hp;
            ffd_pkg::B_MIX: w_gain = r_g_mix;
            ffd_pkg::B_FB:  w_gain = r_g_fb;
        endcase
        w_mul_b = $signed({1'b0, w_gain});
    end

    // Rounding of the registered product, half toward plus infinity
    assign w_prod_x   = SUM_W'(r_prod);
    assign w_t_coef   = w_prod_x + HALF_COEF;
    assign w_rnd_coef = w_t_coef >>> ffd_pkg::COEFF_SHIFT;
    assign w_t_out    = w_prod_x + HALF_OUT;
    assign w_rnd_out  = w_t_out >>> SH_OUT;
    assign w_lp_x     = SUM_W'(r_lp);
    assign w_x_x      = SUM_W'(r_x);
    assign w_sat_out  = $signed(sat_sample(w_x_x + w_rnd_out));

    // Configuration writes, gains capped on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= AB'(ffd_pkg::RST_DELAY);
            r_g_fb  <= GB'(ffd_pkg::RST_FB);
            r_g_mix <= GB'(ffd_pkg::RST_MIX);
            r_a_lp  <= GB'(ffd_pkg::RST_LP);
            r_a_hp  <= GB'(ffd_pkg::RST_HP);
        end else if (i_cfg_we) begin
            unique case (ffd_pkg::t_cfg_idx'(i_cfg_index))
                ffd_pkg::CFG_DELAY: begin
                    if (i_cfg_data == '0 || 32'(i_cfg_data) >= ffd_pkg::DEPTH) begin
                        r_delay <= '0;
                    end else begin
                        r_delay <= i_cfg_data[AB-1:0];
                    end
                end
                ffd_pkg::CFG_FB: begin
                    if (32'(i_cfg_data[ffd_pkg::FB_BITS-1:0]) > ffd_pkg::FEEDBACK_MAX) begin
                        r_g_fb <= GB'(ffd_pkg::FEEDBACK_MAX);
                    end else begin
                        r_g_fb <= GB'(i_cfg_data[ffd_pkg::FB_BITS-1:0]);
                    end
                end
                ffd_pkg::CFG_MIX: begin
                    if (32'(i_cfg_data[GB-1:0]) > ffd_pkg::UNITY) begin
                        r_g_mix <= GB'(ffd_pkg::UNITY);
                    end else begin
                        r_g_mix <= i_cfg_data[GB-1:0];
                    end
                end
                ffd_pkg::CFG_LP: begin
                    if (32'(i_cfg_data[GB-1:0]) > ffd_pkg::UNITY) begin
                        r_a_lp <= GB'(ffd_pkg::UNITY);
                    end else begin
                        r_a_lp <= i_cfg_data[GB-1:0];
                    end
                end
                ffd_pkg::CFG_HP: begin
                    if (32'(i_cfg_data[GB-1:0]) > ffd_pkg::UNITY) begin
                        r_a_hp <= GB'(ffd_pkg::UNITY);
                    end else begin
                        r_a_hp <= i_cfg_data[GB-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Echo store: read on load, write back on the last step
    always_ff @(posedge i_clk) begin
        if (w_adv && w_ctrl.load) begin
            r_rdata <= r_mem[w_rd];
        end
        if (w_adv && w_ctrl.store) begin
            r_mem[r_wp] <= sat_sample(w_x_x + w_rnd_out);
        end
    end

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (w_adv && w_ctrl.load) begin
            r_x     <= i_sample_in;
            r_rd_ok <= ({1'b0, w_rd} < r_fill);
        end
        if (w_ctrl.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (w_ctrl.lp_upd) begin
            r_lp_new <= $signed(sat_state(w_lp_x + w_rnd_coef));
        end
        if (w_ctrl.y_upd) begin
            r_y <= w_sat_out;
        end
        if (w_adv && w_ctrl.store) begin
            r_out <= r_y;
        end
    end

    // Step counter, pointers, filter state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ffd_pkg::STEP_LOAD;
            r_wp        <= '0;
            r_fill      <= '0;
            r_lp        <= '0;
            r_hp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= w_jump ? w_ctrl.target : r_step + 1'b1;
            if (w_ctrl.hp_upd) begin
                r_hp <= $signed(sat_state(w_rnd_coef));
                r_lp <= r_lp_new;
            end
            if (w_adv && w_ctrl.store) begin
                r_wp        <= r_wp + 1'b1;
                r_out_valid <= 1'b1;
                if (32'(r_fill) != ffd_pkg::DEPTH) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
